[sv/tts_pkg.sv]
`timescale 1ns / 1ps

package tts_pkg;

  // default geometry, handed to the top level parameters
  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_TAB_STEP = 4;

  // fixed field widths
  localparam int BYTE_W     = 8;
  localparam int CHAR_W     = 7;
  localparam int COL_IN_W   = 7;
  localparam int ROW_IN_W   = 6;
  localparam int COLS_W     = 8;
  localparam int ROWS_W     = 7;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // register reset values
  localparam logic [COLS_W-1:0] COLS_RESET = 8'd120;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd60;

  // control characters and printable range
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_READ,
    KIND_CR,
    KIND_TAB,
    KIND_LF,
    KIND_PRINT,
    KIND_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [CHAR_W-1:0]    ch;
    logic [COL_IN_W-1:0]  col;
    logic [ROW_IN_W-1:0]  row;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRINT_MAP,
    ST_CLEAR,
    ST_READ_MAP,
    ST_READ_CELL,
    ST_SCROLL,
    ST_SC_FIRST,
    ST_SC_MOVE,
    ST_SC_LAST
  } state_t;

  // sort one incoming transaction into the work the back end has to do
  function automatic kind_t classify(input logic mode, input logic [BYTE_W-1:0] b);
    kind_t k;
    if (mode) begin
      k = KIND_READ;
    end else if (b == CH_CR) begin
      k = KIND_CR;
    end else if (b == CH_TAB) begin
      k = KIND_TAB;
    end else if (b == CH_LF) begin
      k = KIND_LF;
    end else if (b >= PRINT_LO && b <= PRINT_HI) begin
      k = KIND_PRINT;
    end else begin
      k = KIND_IGNORE;
    end
    return k;
  endfunction

endpackage

[sv/text_terminal_screen_writer.sv]
// With the back end idle, a CR, tab, newline or ignored byte is handled as it leaves the queue;
// a printable byte first passes the row map read state, a read the map and cell read states.
// One control byte per cycle while the result is taken and no scroll is due; other work ends
// before the next item leaves the queue. A first write into a blank row clears the row, and a
// scroll rotates the row map, paced by its single read and write port. Reset (rst, synchronous)
// empties the queue, homes the cursor and blanks the screen at once through per-row valid bits.
`timescale 1ns / 1ps

module text_terminal_screen_writer
  import tts_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int TAB_STEP = DEF_TAB_STEP
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [BYTE_W-1:0]     byte_in,
  input  logic [COL_IN_W-1:0]   read_col,
  input  logic [ROW_IN_W-1:0]   read_row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     cell_char,
  output logic [COL_IN_W-1:0]   cursor_col,
  output logic [ROW_IN_W-1:0]   cursor_row,
  output logic                  scrolled
);

  localparam int NW = $clog2(MAX_COLS) + 1;
  localparam int MW = $clog2(MAX_ROWS) + 1;

  logic [COLS_W-1:0] columns;
  logic [ROWS_W-1:0] rows;
  logic [NW-1:0]     nc;
  logic [MW-1:0]     nr;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= COLS_RESET;
      rows    <= ROWS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COLUMNS: columns <= cfg_data;
        REG_ROWS:    rows    <= cfg_data[ROWS_W-1:0];
      endcase
    end
  end

  // geometry in use, clamped to the storage
  always_comb begin
    if (columns == '0) begin
      nc = NW'(1);
    end else if (9'(columns) > 9'(MAX_COLS)) begin
      nc = NW'(MAX_COLS);
    end else begin
      nc = NW'(columns);
    end
    if (rows == '0) begin
      nr = MW'(1);
    end else if (8'(rows) > 8'(MAX_ROWS)) begin
      nr = MW'(MAX_ROWS);
    end else begin
      nr = MW'(rows);
    end
  end

  tts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .byte_in  (byte_in),
    .read_col (read_col),
    .read_row (read_row),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tts_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .nc         (nc),
    .nr         (nr),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_char  (cell_char),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled)
  );

  // back end only takes work that the queue holds
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a scrolling transaction leaves the cursor on the bottom row in use
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_row == ROW_IN_W'(nr - MW'(1))
                                 && 9'(cursor_col) < 9'(nc)))
    else $error("cursor off the bottom row after scroll");

  // the back end never pulls the next item while a result is held by the stall
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !q_pop)
    else $error("new item started while result still pending");

endmodule

[sv/tts_ram.sv]
`timescale 1ns / 1ps

module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/tts_front.sv]
`timescale 1ns / 1ps

module tts_front
  import tts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [BYTE_W-1:0]   byte_in,
  input  logic [COL_IN_W-1:0] read_col,
  input  logic [ROW_IN_W-1:0] read_row,
  output logic                q_valid,
  output item_t               q_item,
  input  logic                q_pop
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CNTW = $clog2(QDEPTH + 1);

  item_t           fifo_mem [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            push;
  item_t           entry;

  // classify the transaction on its way into the queue
  always_comb begin
    entry.kind = classify(mode, byte_in);
    entry.ch   = byte_in[CHAR_W-1:0];
    entry.col  = read_col;
    entry.row  = read_row;
  end

  assign in_stall = (count == CNTW'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = fifo_mem[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !q_pop) begin
        count <= count + CNTW'(1);
      end else if (!push && q_pop) begin
        count <= count - CNTW'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= entry;
    end
  end

endmodule

[sv/tts_back.sv]
`timescale 1ns / 1ps

module tts_back
  import tts_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int TAB_STEP = DEF_TAB_STEP
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [$clog2(MAX_COLS):0]   nc,
  input  logic [$clog2(MAX_ROWS):0]   nr,
  input  logic                        q_valid,
  input  item_t                       q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [CHAR_W-1:0]           cell_char,
  output logic [COL_IN_W-1:0]         cursor_col,
  output logic [ROW_IN_W-1:0]         cursor_row,
  output logic                        scrolled
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int NW = CW + 1;
  localparam int RW = $clog2(MAX_ROWS);
  localparam int MW = RW + 1;
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
  localparam int TW = NW + 5;
  localparam logic [CW-1:0] CLR_LAST = CW'(MAX_COLS - 1);

  state_t            state;
  state_t            state_next;
  logic [CW-1:0]     cur_x;
  logic [CW-1:0]     cur_x_next;
  logic [RW-1:0]     cur_y;
  logic [RW-1:0]     cur_y_next;
  logic              wrap;
  logic              wrap_next;
  item_t             item;
  logic [RW-1:0]     phys;
  logic [RW-1:0]     first_row;
  logic [RW-1:0]     idx;
  logic [CW-1:0]     clr_cnt;
  logic              read_ok;
  logic [MAX_ROWS-1:0] map_vld;
  logic [MAX_ROWS-1:0] row_vld;
  logic              map_rd_def;
  logic [RW-1:0]     map_rd_addr;

  // memory ports
  logic              map_we;
  logic [RW-1:0]     map_wa;
  logic [RW-1:0]     map_wd;
  logic              map_re;
  logic [RW-1:0]     map_ra;
  logic [RW-1:0]     map_q;
  logic [RW-1:0]     map_val;
  logic              scr_we;
  logic [AW-1:0]     scr_wa;
  logic [CHAR_W-1:0] scr_wd;
  logic              scr_re;
  logic [AW-1:0]     scr_ra;
  logic [CHAR_W-1:0] scr_q;

  // step arithmetic
  logic              slot_free;
  logic [CW-1:0]     cx_c;
  logic [RW-1:0]     cy_c;
  logic [RW-1:0]     nr_last;
  logic [TW-1:0]     x_tab;
  logic [CW-1:0]     tab_x;
  logic [MW-1:0]     ly;
  logic              lf_scroll;
  logic [NW-1:0]     px;
  logic              p_wrap;
  logic [MW-1:0]     py;
  logic              p_scroll;
  logic              emit;
  logic [CHAR_W-1:0] emit_cell;
  logic              emit_scroll;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
  endfunction

  // logical to physical row map, identity where never written
  tts_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ROWS)
  ) u_map (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (map_wa),
    .wr_data (map_wd),
    .rd_en   (map_re),
    .rd_addr (map_ra),
    .rd_data (map_q)
  );

  // character cells, rows stored physically
  tts_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_ROWS * MAX_COLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (scr_we),
    .wr_addr (scr_wa),
    .wr_data (scr_wd),
    .rd_en   (scr_re),
    .rd_addr (scr_ra),
    .rd_data (scr_q)
  );

  assign map_val = map_rd_def ? map_rd_addr : map_q;

  // cursor arithmetic shared by next state and outputs
  always_comb begin
    slot_free = !out_valid || !out_stall;
    cx_c      = (NW'(cur_x) >= nc) ? CW'(nc - NW'(1)) : cur_x;
    cy_c      = (MW'(cur_y) >= nr) ? RW'(nr - MW'(1)) : cur_y;
    nr_last   = RW'(nr - MW'(1));
    x_tab     = TW'(cx_c) + TW'(TAB_STEP);
    tab_x     = (x_tab >= TW'(nc)) ? CW'(nc - NW'(1)) : CW'(x_tab);
    ly        = MW'(cy_c) + (wrap ? MW'(0) : MW'(1));
    lf_scroll = (ly >= nr);
    px        = NW'(cur_x) + NW'(1);
    p_wrap    = (px >= nc);
    py        = MW'(cur_y) + MW'(p_wrap);
    p_scroll  = (py >= nr);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          case (q_item.kind)
            KIND_READ:  state_next = ST_READ_MAP;
            KIND_PRINT: state_next = ST_PRINT_MAP;
            KIND_LF:    state_next = lf_scroll ? ST_SCROLL : ST_IDLE;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_PRINT_MAP: begin
        if (row_vld[map_val]) begin
          state_next = p_scroll ? ST_SCROLL : ST_IDLE;
        end else begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) begin
          state_next = p_scroll ? ST_SCROLL : ST_IDLE;
        end
      end
      ST_READ_MAP:  state_next = ST_READ_CELL;
      ST_READ_CELL: state_next = ST_IDLE;
      ST_SCROLL:    state_next = ST_SC_FIRST;
      ST_SC_FIRST:  state_next = (nr == MW'(1)) ? ST_SC_LAST : ST_SC_MOVE;
      ST_SC_MOVE: begin
        if (MW'(idx) + MW'(2) >= nr) begin
          state_next = ST_SC_LAST;
        end
      end
      ST_SC_LAST:   state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs: memory controls, cursor update, result strobe
  always_comb begin
    q_pop       = 1'b0;
    map_we      = 1'b0;
    map_wa      = idx;
    map_wd      = map_val;
    map_re      = 1'b0;
    map_ra      = '0;
    scr_we      = 1'b0;
    scr_wa      = cell_addr(phys, clr_cnt);
    scr_wd      = '0;
    scr_re      = 1'b0;
    scr_ra      = cell_addr(map_val, CW'(item.col));
    cur_x_next  = cur_x;
    cur_y_next  = cur_y;
    wrap_next   = wrap;
    emit        = 1'b0;
    emit_cell   = '0;
    emit_scroll = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop  = 1'b1;
          map_re = 1'b1;
          map_ra = (q_item.kind == KIND_READ) ? RW'(q_item.row) : cy_c;
          case (q_item.kind)
            KIND_READ: begin
            end
            KIND_CR: begin
              cur_x_next = '0;
              cur_y_next = cy_c;
              emit       = 1'b1;
            end
            KIND_TAB: begin
              cur_x_next = tab_x;
              cur_y_next = cy_c;
              emit       = 1'b1;
            end
            KIND_LF: begin
              cur_x_next = cx_c;
              cur_y_next = lf_scroll ? nr_last : RW'(ly);
              wrap_next  = 1'b0;
              emit       = !lf_scroll;
            end
            KIND_PRINT: begin
              cur_x_next = cx_c;
              cur_y_next = cy_c;
            end
            default: begin
              cur_x_next = cx_c;
              cur_y_next = cy_c;
              emit       = 1'b1;
            end
          endcase
        end
      end
      ST_PRINT_MAP: begin
        if (row_vld[map_val]) begin
          scr_we     = 1'b1;
          scr_wa     = cell_addr(map_val, cur_x);
          scr_wd     = item.ch;
          cur_x_next = p_wrap ? '0 : CW'(px);
          cur_y_next = p_scroll ? nr_last : RW'(py);
          wrap_next  = p_wrap;
          emit       = !p_scroll;
        end
      end
      ST_CLEAR: begin
        // blank the fresh row and drop the character in on the way
        scr_we = 1'b1;
        scr_wd = (clr_cnt == cur_x) ? item.ch : '0;
        if (clr_cnt == CLR_LAST) begin
          cur_x_next = p_wrap ? '0 : CW'(px);
          cur_y_next = p_scroll ? nr_last : RW'(py);
          wrap_next  = p_wrap;
          emit       = !p_scroll;
        end
      end
      ST_READ_MAP: begin
        scr_re = 1'b1;
      end
      ST_READ_CELL: begin
        emit      = 1'b1;
        emit_cell = read_ok ? scr_q : '0;
      end
      ST_SCROLL: begin
        map_re = 1'b1;
        map_ra = '0;
      end
      ST_SC_FIRST: begin
        map_re = (nr != MW'(1));
        map_ra = RW'(1);
      end
      ST_SC_MOVE: begin
        map_we = 1'b1;
        map_re = 1'b1;
        map_ra = RW'(MW'(idx) + MW'(2));
      end
      ST_SC_LAST: begin
        map_we      = 1'b1;
        map_wa      = nr_last;
        map_wd      = first_row;
        emit        = 1'b1;
        emit_scroll = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cur_x   <= '0;
      cur_y   <= '0;
      wrap    <= 1'b0;
      map_vld <= '0;
      row_vld <= '0;
    end else begin
      state <= state_next;
      cur_x <= cur_x_next;
      cur_y <= cur_y_next;
      wrap  <= wrap_next;
      if (map_we) begin
        map_vld[map_wa] <= 1'b1;
      end
      if (state == ST_CLEAR && clr_cnt == CLR_LAST) begin
        row_vld[phys] <= 1'b1;
      end
      if (state == ST_SC_LAST) begin
        row_vld[first_row] <= 1'b0;
      end
    end
  end

  // work registers of the item in flight
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
    end
    if (map_re) begin
      map_rd_def  <= !map_vld[map_ra];
      map_rd_addr <= map_ra;
    end
    if (state == ST_PRINT_MAP || state == ST_READ_MAP) begin
      phys <= map_val;
    end
    if (state == ST_READ_MAP) begin
      read_ok <= (9'(item.col) < 9'(nc)) && (8'(item.row) < 8'(nr)) && row_vld[map_val];
    end
    if (state == ST_PRINT_MAP) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + CW'(1);
    end
    if (state == ST_SC_FIRST) begin
      first_row <= map_val;
    end
    if (state == ST_SCROLL) begin
      idx <= '0;
    end else if (state == ST_SC_MOVE) begin
      idx <= idx + RW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cell_char  <= emit_cell;
      cursor_col <= COL_IN_W'(cur_x_next);
      cursor_row <= ROW_IN_W'(cur_y_next);
      scrolled   <= emit_scroll;
    end
  end

endmodule

[test/tb_text_terminal_screen_writer.sv]
`timescale 1ns / 1ps

module tb_text_terminal_screen_writer;
  import tts_pkg::*;

  localparam int NCOLS       = DEF_MAX_COLS;
  localparam int NROWS       = DEF_MAX_ROWS;
  localparam int TAB_COLS    = DEF_TAB_STEP;
  localparam int SETTLE_CYC  = 300;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_CYC    = 160;

  typedef struct packed {
    logic                mode;
    logic [BYTE_W-1:0]   b;
    logic [COL_IN_W-1:0] col;
    logic [ROW_IN_W-1:0] row;
  } host_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   ch;
    logic [COL_IN_W-1:0] col;
    logic [ROW_IN_W-1:0] row;
    logic                scr;
  } cell_report_t;

  // dut signals, inputs known from time zero
  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic                  mode       = 1'b0;
  logic [BYTE_W-1:0]     byte_in    = '0;
  logic [COL_IN_W-1:0]   read_col   = '0;
  logic [ROW_IN_W-1:0]   read_row   = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [CHAR_W-1:0]     cell_char;
  logic [COL_IN_W-1:0]   cursor_col;
  logic [ROW_IN_W-1:0]   cursor_row;
  logic                  scrolled;

  // shadow screen and cursor
  logic [CHAR_W-1:0] shadow_cells [0:NCOLS*NROWS-1];
  int unsigned       shadow_x;
  int unsigned       shadow_y;
  bit                shadow_wrap;
  logic [COLS_W-1:0] shadow_cols;
  logic [ROWS_W-1:0] shadow_rows;

  host_item_t   host_queue[$];
  cell_report_t screen_reports[$];
  host_item_t   on_wire;
  int           fail_cnt    = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;

  text_terminal_screen_writer i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .byte_in    (byte_in),
    .read_col   (read_col),
    .read_row   (read_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_char  (cell_char),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned cols_in_use();
    if (shadow_cols == 0) return 1;
    if (shadow_cols > NCOLS) return NCOLS;
    return 32'(shadow_cols);
  endfunction

  function automatic int unsigned rows_in_use();
    if (shadow_rows == 0) return 1;
    if (shadow_rows > NROWS) return NROWS;
    return 32'(shadow_rows);
  endfunction

  // apply one transaction to the shadow screen and return what the block should report
  function automatic cell_report_t apply_to_screen(input host_item_t it);
    int unsigned  nc;
    int unsigned  nr;
    cell_report_t r;
    nc = cols_in_use();
    nr = rows_in_use();
    r  = '0;
    if (it.mode) begin
      if (it.col < nc && it.row < nr) r.ch = shadow_cells[it.row * NCOLS + it.col];
    end else begin
      if (shadow_x >= nc) shadow_x = nc - 1;
      if (shadow_y >= nr) shadow_y = nr - 1;
      if (it.b == CH_CR) begin
        shadow_x = 0;
      end else if (it.b == CH_TAB) begin
        shadow_x += TAB_COLS;
        if (shadow_x >= nc) shadow_x = nc - 1;
      end else if (it.b == CH_LF) begin
        if (!shadow_wrap) shadow_y++;
        shadow_wrap = 1'b0;
      end else if (it.b >= PRINT_LO && it.b <= PRINT_HI) begin
        shadow_cells[shadow_y * NCOLS + shadow_x] = it.b[CHAR_W-1:0];
        shadow_x++;
        if (shadow_x >= nc) begin
          shadow_x    = 0;
          shadow_y++;
          shadow_wrap = 1'b1;
        end else begin
          shadow_wrap = 1'b0;
        end
      end
      // scroll up one row, blank the bottom row in use
      if (shadow_y >= nr) begin
        for (int i = 0; i < (nr - 1) * NCOLS; i++) shadow_cells[i] = shadow_cells[i + NCOLS];
        for (int c = 0; c < NCOLS; c++) shadow_cells[(nr - 1) * NCOLS + c] = '0;
        shadow_y = nr - 1;
        r.scr    = 1'b1;
      end
    end
    r.col = shadow_x[COL_IN_W-1:0];
    r.row = shadow_y[ROW_IN_W-1:0];
    return r;
  endfunction

  function automatic host_item_t feed(input logic [BYTE_W-1:0] b);
    host_item_t it;
    it.mode = 1'b0;
    it.b    = b;
    it.col  = COL_IN_W'($urandom_range(0, 127));
    it.row  = ROW_IN_W'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic host_item_t peek(input int unsigned c, input int unsigned r);
    host_item_t it;
    it.mode = 1'b1;
    it.b    = BYTE_W'($urandom_range(0, 255));
    it.col  = COL_IN_W'(c);
    it.row  = ROW_IN_W'(r);
    return it;
  endfunction

  // mostly text with line control, some reads, some arbitrary bytes
  function automatic host_item_t random_item();
    host_item_t  it;
    int unsigned pick;
    it   = feed(BYTE_W'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.mode = 1'b1;
      if ($urandom_range(0, 4) != 0) begin
        it.col = COL_IN_W'($urandom_range(0, cols_in_use() - 1));
        it.row = ROW_IN_W'($urandom_range(0, rows_in_use() - 1));
      end
    end else if (pick < 60) begin
      it.b = BYTE_W'($urandom_range(PRINT_LO, PRINT_HI));
    end else if (pick < 72) begin
      it.b = CH_LF;
    end else if (pick < 80) begin
      it.b = CH_CR;
    end else if (pick < 87) begin
      it.b = CH_TAB;
    end
    return it;
  endfunction

  // driver: predicts each accepted transaction, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) screen_reports.push_back(apply_to_screen(on_wire));
      if (!in_valid || !in_stall) begin
        if (host_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          on_wire  = host_queue.pop_front();
          mode     <= on_wire.mode;
          byte_in  <= on_wire.b;
          read_col <= on_wire.col;
          read_row <= on_wire.row;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // monitor: checks results and stalls the output, with one long hold-off
  int           results_seen = 0;
  int           hold_left    = 0;
  cell_report_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (screen_reports.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_cnt++;
        end else begin
          want = screen_reports.pop_front();
          check_field("cell_char", 32'(want.ch), 32'(cell_char));
          check_field("cursor_col", 32'(want.col), 32'(cursor_col));
          check_field("cursor_row", 32'(want.row), 32'(cursor_row));
          check_field("scrolled", 32'(want.scr), 32'(scrolled));
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_CYC;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  task automatic reg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_COLUMNS) shadow_cols = data;
    else shadow_rows = data[ROWS_W-1:0];
  endtask

  // wait for every transaction to be sent and answered, then let the block settle
  task automatic drain();
    @(negedge clk);
    while (host_queue.size() != 0 || in_valid || screen_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rws,
                           input int n_items, input int tx_pct, input int rx_pct);
    reg_write(REG_COLUMNS, cols);
    reg_write(REG_ROWS, rws);
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_items; i++) host_queue.push_back(random_item());
    drain();
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < NCOLS * NROWS; i++) shadow_cells[i] = '0;
    shadow_x    = 0;
    shadow_y    = 0;
    shadow_wrap = 1'b0;
    shadow_cols = COLS_RESET;
    shadow_rows = ROWS_RESET;
    tx_idle_pct = 36;
    rx_idle_pct = 53;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: field extremes, reads in and out of the area in use
    host_queue.push_back(peek(0, 0));
    host_queue.push_back(peek(127, 63));
    host_queue.push_back(peek(119, 59));
    host_queue.push_back(peek(120, 0));
    host_queue.push_back(feed(8'h00));
    host_queue.push_back(feed(8'hFF));
    host_queue.push_back(feed(8'h7F));
    host_queue.push_back(feed(PRINT_LO));
    host_queue.push_back(feed(PRINT_HI));
    host_queue.push_back(feed(CH_CR));
    host_queue.push_back(feed(CH_TAB));
    drain();

    // tiny screen: clamped cursor, wrap then newline, scroll, tab clamp
    reg_write(REG_COLUMNS, 8'd4);
    reg_write(REG_ROWS, 8'd2);
    host_queue.push_back(peek(0, 0));
    host_queue.push_back(feed("A"));
    host_queue.push_back(feed("B"));
    host_queue.push_back(feed("C"));
    host_queue.push_back(feed("D"));
    host_queue.push_back(feed(CH_LF));
    host_queue.push_back(feed(CH_LF));
    host_queue.push_back(feed("E"));
    host_queue.push_back(feed("F"));
    host_queue.push_back(feed("G"));
    host_queue.push_back(feed("H"));
    host_queue.push_back(feed(CH_TAB));
    host_queue.push_back(feed(CH_TAB));
    host_queue.push_back(feed(CH_CR));
    host_queue.push_back(peek(3, 0));
    drain();

    // random traffic over a range of geometries and idling patterns
    run_phase(8'd1, 8'd1, 100, 36, 53);
    run_phase(8'd128, 8'd64, 150, 36, 53);
    run_phase(8'd0, 8'd0, 100, 36, 53);
    run_phase(8'd255, 8'hFF, 100, 53, 36);
    run_phase(8'd6, 8'd3, 150, 53, 36);
    run_phase(CFG_DATA_W'($urandom_range(1, 16)), CFG_DATA_W'($urandom_range(1, 8)),
              150, 53, 36);
    run_phase(8'd2, 8'h85, 150, 0, 0);
    run_phase(CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)),
              150, 0, 0);
    run_phase(8'd3, 8'd64, 100, 0, 0);
    run_phase(COLS_RESET, {1'b0, ROWS_RESET}, 100, 0, 0);

    if (fail_cnt == 0) begin
      $display("text_terminal_screen_writer regression: pass");
    end else begin
      $display("text_terminal_screen_writer regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("text_terminal_screen_writer regression: fail");
    $finish;
  end

endmodule
